// ===== hw/rtl/sha1_pkg.sv =====
// SHA-1 engine shared types and constants.
// Depends on nothing; imported by sha1_ctrl, sha1_dp, sha1_hash_engine and tb_top.
`default_nettype none

package sha1_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int ROUND_BITS   = 7;
    localparam int BLOCK_BITS   = 512;

    typedef logic [31:0]           t_word;
    typedef logic [ROUND_BITS-1:0] t_round;
    typedef logic [2:0]            t_widx;
    typedef logic [5:0]            t_fill;

    localparam t_word H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam t_fill      FILL_LAST  = 6'd63;
    localparam t_fill      FILL_PRELEN = 6'd55;
    localparam t_round     ROUND_LAST = t_round'(ROUNDS - 1);
    localparam t_widx      WIDX_LAST  = t_widx'(DIGEST_WORDS - 1);

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      push;
        logic      count_len;
        t_byte_sel sel;
        logic      round_init;
        logic      round_step;
        logic      add_chain;
        logic      emit_step;
    } t_dp_cmd;

    typedef struct packed {
        t_fill fill;
        logic  round_last;
        logic  emit_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/sha1_dp.sv =====
// SHA-1 datapath: message window, round registers, chaining words, counters.
// Depends on sha1_pkg; driven by sha1_ctrl commands.
`default_nettype none

module sha1_dp
    import sha1_pkg::*;
#(
    parameter int LEN_BITS = 61
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [7:0] i_data_byte,
    output t_dp_stat        o_stat,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);

    logic [BLOCK_BITS-1:0] r_win;
    t_word                 r_a, r_b, r_c, r_d, r_e;
    t_word                 r_h [DIGEST_WORDS];
    t_fill                 r_fill;
    logic [LEN_BITS-1:0]   r_len;
    t_round                r_round;
    t_widx                 r_widx;

    logic [63:0] len_bits;
    logic [2:0]  len_pos;
    logic [7:0]  push_byte;
    t_word       w0, w2, w8, w13, w_mix, w_new;
    t_word       f_val, k_val;
    t_word       n_a;
    logic [1:0]  stage;

    assign len_bits = 64'(r_len) << 3;
    assign len_pos  = 3'd7 - r_fill[2:0];

    always_comb begin
        unique case (i_cmd.sel)
            SEL_DATA: push_byte = i_data_byte;
            SEL_PAD:  push_byte = PAD_BYTE;
            SEL_ZERO: push_byte = 8'h00;
            SEL_LEN:  push_byte = 8'(len_bits >> {len_pos, 3'b000});
            default:  push_byte = 8'h00;
        endcase
    end

    // window word i sits at the top minus 32*i
    assign w0    = r_win[BLOCK_BITS-1 -: 32];
    assign w2    = r_win[BLOCK_BITS-1-32*2 -: 32];
    assign w8    = r_win[BLOCK_BITS-1-32*8 -: 32];
    assign w13   = r_win[BLOCK_BITS-1-32*13 -: 32];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        if (r_round < t_round'(20)) begin
            stage = 2'd0;
        end else if (r_round < t_round'(40)) begin
            stage = 2'd1;
        end else if (r_round < t_round'(60)) begin
            stage = 2'd2;
        end else begin
            stage = 2'd3;
        end
    end

    always_comb begin
        case (stage)
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd2:    f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default: f_val = r_b ^ r_c ^ r_d;
        endcase
        k_val = K_ROUND[stage];
    end

    assign n_a = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win <= {r_win[BLOCK_BITS-9:0], push_byte};
        end else if (i_cmd.round_step) begin
            r_win <= {r_win[BLOCK_BITS-33:0], w_new};
        end
        if (i_cmd.round_init) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_step) begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= H_INIT;
            r_fill  <= '0;
            r_len   <= '0;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + t_fill'(1);
            end
            if (i_cmd.count_len) begin
                r_len <= r_len + LEN_BITS'(1);
            end
            if (i_cmd.round_init) begin
                r_round <= '0;
            end else if (i_cmd.round_step) begin
                r_round <= r_round + t_round'(1);
            end
            if (i_cmd.add_chain) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.emit_step) begin
                if (r_widx == WIDX_LAST) begin
                    r_widx <= '0;
                    r_h    <= H_INIT;
                    r_len  <= '0;
                end else begin
                    r_widx <= r_widx + t_widx'(1);
                end
            end
        end
    end

    assign o_stat.fill       = r_fill;
    assign o_stat.round_last = (r_round == ROUND_LAST);
    assign o_stat.emit_last  = (r_widx == WIDX_LAST);

    assign o_digest_word = r_h[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == WIDX_LAST);

endmodule

`default_nettype wire

// ===== hw/rtl/sha1_ctrl.sv =====
// SHA-1 controller: byte intake, padding sequence, compression and digest beats.
// Depends on sha1_pkg; commands sha1_dp.
`default_nettype none

module sha1_ctrl
    import sha1_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_byte_present,
    input  wire logic     i_finish,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state r_ret;
    logic   accept;
    logic   full;

    assign accept = i_start && (r_state == S_IDLE);
    assign full   = (i_stat.fill == FILL_LAST);

    always_comb begin
        o_cmd     = '0;
        o_cmd.sel = SEL_DATA;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.push       = accept && i_byte_present;
                o_cmd.count_len  = accept && i_byte_present;
                o_cmd.round_init = accept && i_byte_present && full;
            end
            S_PAD80: begin
                o_cmd.push       = 1'b1;
                o_cmd.sel        = SEL_PAD;
                o_cmd.round_init = full;
            end
            S_PADZ: begin
                o_cmd.push       = 1'b1;
                o_cmd.sel        = SEL_ZERO;
                o_cmd.round_init = full;
            end
            S_PADLEN: begin
                o_cmd.push       = 1'b1;
                o_cmd.sel        = SEL_LEN;
                o_cmd.round_init = full;
            end
            S_ROUND: o_cmd.round_step = 1'b1;
            S_ADD:   o_cmd.add_chain  = 1'b1;
            S_EMIT:  o_cmd.emit_step  = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                    if (accept) begin
                        if (i_byte_present && full) begin
                            r_state <= S_ROUND;
                            r_ret   <= i_finish ? S_PAD80 : S_IDLE;
                        end else if (i_finish) begin
                            r_state <= S_PAD80;
                        end
                    end
                end
                S_PAD80, S_PADZ: begin
                    if (full) begin
                        r_state <= S_ROUND;
                        r_ret   <= S_PADZ;
                    end else if (i_stat.fill == FILL_PRELEN) begin
                        r_state <= S_PADLEN;
                    end else begin
                        r_state <= S_PADZ;
                    end
                end
                S_PADLEN: begin
                    if (full) begin
                        r_state <= S_ROUND;
                        r_ret   <= S_EMIT;
                    end
                end
                S_ROUND: begin
                    if (i_stat.round_last) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD:  r_state <= r_ret;
                S_EMIT: begin
                    if (i_stat.emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_round_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> !o_cmd.push)
        else $error("byte pushed during compression");

    a_full_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push && full) |=> (r_state == S_ROUND))
        else $error("full block not compressed");

    a_emit_from_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_ADD))
        else $error("digest beats without final compression");

endmodule

`default_nettype wire

// ===== hw/rtl/sha1_hash_engine.sv =====
// SHA-1 hash engine top level: controller plus datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_dp.
// A byte that fills a block starts a compression: 80 rounds, then a chain add.
// Finish: 9 to 72 pad bytes and 1 or 2 compressions, then 5 digest beats on consecutive
// cycles; o_valid marks each, receiver cannot stall.
// Synchronous active-low reset restores h0..h4, clears byte and length counters.
`default_nettype none

module sha1_hash_engine
    import sha1_pkg::*;
#(
    parameter int LENGTH_COUNT_BITS = 61
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_finish,
    output logic             o_valid,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sha1_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_byte_present (i_byte_present),
        .i_finish       (i_finish),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_valid        (o_valid)
    );

    sha1_dp #(
        .LEN_BITS (LENGTH_COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_stat        (stat),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    a_beats_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_word) |=> (o_valid && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest beats broken");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word) |=> !o_valid)
        else $error("beat after last digest word");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_finish) |=> busy)
        else $error("finish accepted without padding");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sha1_hash_engine: directed and random messages, digest predicted
// in the bench and compared word by word. Depends on sha1_pkg and sha1_hash_engine only.
`timescale 1ns / 1ps

module tb_top;
    import sha1_pkg::*;

    localparam int LEN_BITS = 61;
    localparam int ITEM_TARGET = 410;
    localparam int BTB_ITEMS = 125;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] RC [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_finish = 1'b0;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    logic [31:0]   chain [5];
    logic [7:0]    blk [64];
    int unsigned   blk_fill;
    logic [LEN_BITS-1:0] byte_count;
    t_digest_beat  digest_q [$];
    int            fail_count = 0;
    int            item_count = 0;
    bit            idle_en = 1'b1;

    sha1_hash_engine #(.LENGTH_COUNT_BITS(LEN_BITS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_finish       (i_finish),
        .o_valid        (o_valid),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL sha1_hash_engine");
        $finish;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic hash_restart();
        for (int i = 0; i < 5; i++) chain[i] = IV[i];
        blk_fill = 0;
        byte_count = '0;
    endtask

    task automatic sha_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = RC[0];
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = RC[1];
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RC[2];
            end else begin
                f = b ^ c ^ d;
                k = RC[3];
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic block_push(input logic [7:0] v);
        blk[blk_fill] = v;
        blk_fill++;
        if (blk_fill == 64) begin
            sha_compress();
            blk_fill = 0;
        end
    endtask

    // predicts the effect of one accepted beat, queues the digest on finish
    task automatic sha_absorb(input logic [7:0] b, input logic p, input logic f);
        logic [63:0] bit_len;
        t_digest_beat beat;
        if (p) begin
            block_push(b);
            byte_count++;
        end
        if (f) begin
            bit_len = {byte_count, 3'b000};
            block_push(PAD_MARK);
            while (blk_fill != 56) block_push(8'h00);
            for (int i = 7; i >= 0; i--) block_push(bit_len[8*i +: 8]);
            for (int i = 0; i < 5; i++) begin
                beat.word = chain[i];
                beat.idx  = 3'(i);
                beat.last = (i == 4);
                digest_q.insert(digest_q.size(), beat);
            end
            hash_restart();
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic p, input logic f);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= p;
        i_finish       <= f;
        do @(posedge i_clk); while (busy);
        sha_absorb(b, p, f);
        item_count++;
    endtask

    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n && o_valid) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest beat: word_index %0d, digest_word %08h",
                       o_word_index, o_digest_word);
                fail_count++;
            end else begin
                exp_beat = digest_q.pop_front();
                if (o_digest_word !== exp_beat.word) begin
                    $error("digest_word mismatch: expected %08h, actual %08h",
                           exp_beat.word, o_digest_word);
                    fail_count++;
                end
                if (o_word_index !== exp_beat.idx) begin
                    $error("word_index mismatch: expected %0d, actual %0d",
                           exp_beat.idx, o_word_index);
                    fail_count++;
                end
                if (o_last_word !== exp_beat.last) begin
                    $error("last_word mismatch: expected %0b, actual %0b",
                           exp_beat.last, o_last_word);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_message(input int len, input bit finish_on_byte, input bit noisy);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, finish_on_byte && (i == len - 1));
        end
        if (!finish_on_byte || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'hAA, 1'b1, 1'b1);
    endtask

    task automatic test_ignored_bytes();
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h3C, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_known_vector();
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_random_messages();
        int len;
        int pick;
        while (item_count < ITEM_TARGET - BTB_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                len = $urandom_range(0, 12);
            else if (pick < 8)
                len = 55 + $urandom_range(0, 10);
            else if (pick < 9)
                len = $urandom_range(118, 122);
            else
                len = $urandom_range(0, 200);
            send_message(len, 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        send_message(56, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b0);
        send_message(3, 1'b1, 1'b1);
        send_message(0, 1'b0, 1'b0);
    endtask

    initial begin
        hash_restart();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_message();
        test_byte_extremes();
        test_ignored_bytes();
        test_known_vector();
        test_random_messages();
        test_back_to_back();
        start <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && digest_q.size() == 0) begin
            $display("PASS sha1_hash_engine");
        end else begin
            $display("FAIL sha1_hash_engine");
        end
        $finish;
    end

endmodule
